// File: rtl/decimal_text_to_fixed_parser_macros.svh
// Assertion helpers shared by the parser RTL.
`ifndef DECIMAL_TEXT_TO_FIXED_PARSER_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DTTF_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DTTF_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dttf_pkg.sv
`timescale 1ns / 1ps

package dttf_pkg;

  localparam int MAG_W    = 63;
  localparam int CHAR_W   = 8;
  localparam int VALUE_W  = 64;
  localparam int PLACE_W  = 4;
  localparam int OUT_TDATA_W = 72;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // round(2^64 / 10^k), k = 0..15 (entry 0 unused)
  localparam logic [63:0] TENTH_POW_Q64 [16] = '{
    64'd0,
    64'd1844674407370955162, 64'd184467440737095516, 64'd18446744073709552,
    64'd1844674407370955, 64'd184467440737096, 64'd18446744073710,
    64'd1844674407371, 64'd184467440737, 64'd18446744074,
    64'd1844674407, 64'd184467441, 64'd18446744,
    64'd1844674, 64'd184467, 64'd18447
  };

  typedef enum logic [1:0] {
    PH_START,
    PH_INT,
    PH_POINT,
    PH_FRAC
  } dttf_phase_e;

  typedef struct packed {
    logic                  step;
    logic [CHAR_W-1:0]     character;
  } dttf_step_t;

  typedef struct packed {
    logic                  overflow;
    logic                  valid_res;
    logic [VALUE_W-1:0]    value;
  } dttf_result_t;

endpackage

// File: rtl/dttf_in_reg.sv
`timescale 1ns / 1ps

module dttf_in_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [dttf_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] character
  input  logic                         out_free_i,
  output dttf_pkg::dttf_step_t         step_o
);

  logic                        valid_q, valid_d;
  logic [dttf_pkg::CHAR_W-1:0] char_q, char_d;
  logic                        advance;

  // A NUL needs room in the result register; other bytes always advance.
  assign advance = valid_q && ((char_q != dttf_pkg::CH_NUL) || out_free_i);
  assign s_axis_tready = !valid_q || advance;

  always_comb begin
    valid_d = valid_q;
    char_d  = char_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid;
      char_d  = s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign step_o.step      = advance;
  assign step_o.character = char_q;

endmodule

// File: rtl/dttf_core.sv
`timescale 1ns / 1ps

module dttf_core #(
  parameter int FRAC_BITS       = 32,
  parameter int MAX_FRAC_DIGITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dttf_pkg::dttf_step_t   step_i,
  output dttf_pkg::dttf_result_t res_o
);

  localparam int Sh    = 64 - FRAC_BITS;
  localparam int ProdW = FRAC_BITS + 4;
  localparam int IntW  = dttf_pkg::MAG_W + 4;
  localparam int MagW  = dttf_pkg::MAG_W;
  localparam logic [dttf_pkg::PLACE_W-1:0] MaxPlace = dttf_pkg::PLACE_W'(MAX_FRAC_DIGITS);

  dttf_pkg::dttf_phase_e          phase_q, phase_d;
  logic                           neg_q, neg_d;
  logic                           bad_q, bad_d;
  logic                           sat_q, sat_d;
  logic [MagW-1:0]                mag_q, mag_d;
  logic [dttf_pkg::PLACE_W-1:0]   place_q, place_d;

  logic [7:0]                     ch;
  logic [7:0]                     ch_off;
  logic [3:0]                     digit;
  logic                           is_digit;
  logic [IntW-1:0]                int_sum;
  logic                           int_sat;
  logic [dttf_pkg::PLACE_W-1:0]   place_inc;
  logic [63:0]                    rom_word;
  logic [63:0]                    weight64;
  logic [FRAC_BITS-1:0]           weight;
  logic [ProdW-1:0]               frac_add;
  logic [63:0]                    frac_sum;
  logic                           frac_sat;
  logic                           ok;
  logic [63:0]                    mag_ext;

  assign ch       = step_i.character;
  assign ch_off   = ch - dttf_pkg::CH_ZERO;
  assign digit    = ch_off[3:0];
  assign is_digit = (ch >= dttf_pkg::CH_ZERO) && (ch <= dttf_pkg::CH_NINE);

  // mag*10 + digit<<FRAC_BITS; anything above 63 bits saturates
  assign int_sum = (IntW'(mag_q) << 3) + (IntW'(mag_q) << 1)
                 + (IntW'(digit) << FRAC_BITS);
  assign int_sat = |int_sum[IntW-1:MagW];

  // fraction weight 10^-k at FRAC_BITS, rounded half up
  assign place_inc = place_q + 1'b1;
  assign rom_word  = dttf_pkg::TENTH_POW_Q64[place_inc];
  assign weight64  = (rom_word >> Sh) + ((rom_word >> (Sh - 1)) & 64'd1);
  assign weight    = weight64[FRAC_BITS-1:0];
  assign frac_add  = ProdW'(digit) * ProdW'(weight);
  assign frac_sum  = {1'b0, mag_q} + 64'(frac_add);
  assign frac_sat  = frac_sum[63];

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    bad_d   = bad_q;
    sat_d   = sat_q;
    mag_d   = mag_q;
    place_d = place_q;
    if (step_i.step) begin
      if (ch == dttf_pkg::CH_NUL) begin
        phase_d = dttf_pkg::PH_START;
        neg_d   = 1'b0;
        bad_d   = 1'b0;
        sat_d   = 1'b0;
        mag_d   = '0;
        place_d = '0;
      end else if (!bad_q) begin
        unique case (phase_q)
          dttf_pkg::PH_START, dttf_pkg::PH_INT: begin
            if ((phase_q == dttf_pkg::PH_START) &&
                ((ch == dttf_pkg::CH_PLUS) || (ch == dttf_pkg::CH_MINUS))) begin
              neg_d   = (ch == dttf_pkg::CH_MINUS);
              phase_d = dttf_pkg::PH_INT;
            end else if (is_digit) begin
              if (!sat_q) begin
                if (int_sat) begin
                  mag_d = dttf_pkg::MAG_MAX;
                  sat_d = 1'b1;
                end else begin
                  mag_d = int_sum[MagW-1:0];
                end
              end
              phase_d = dttf_pkg::PH_INT;
            end else if (ch == dttf_pkg::CH_POINT) begin
              phase_d = dttf_pkg::PH_POINT;
            end else begin
              bad_d = 1'b1;
            end
          end
          dttf_pkg::PH_POINT, dttf_pkg::PH_FRAC: begin
            if (is_digit) begin
              if (place_q < MaxPlace) begin
                place_d = place_inc;
                if (!sat_q) begin
                  if (frac_sat) begin
                    mag_d = dttf_pkg::MAG_MAX;
                    sat_d = 1'b1;
                  end else begin
                    mag_d = frac_sum[MagW-1:0];
                  end
                end
              end
              phase_d = dttf_pkg::PH_FRAC;
            end else begin
              bad_d = 1'b1;
            end
          end
          default: begin
            bad_d = 1'b1;
          end
        endcase
      end
    end
  end

  // result as seen by a terminating NUL
  assign mag_ext = {1'b0, mag_q};
  assign ok      = !bad_q && (phase_q != dttf_pkg::PH_POINT);

  always_comb begin
    res_o.valid_res = ok;
    res_o.overflow  = ok && sat_q;
    res_o.value     = '0;
    if (ok) begin
      res_o.value = neg_q ? (64'd0 - mag_ext) : mag_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dttf_pkg::PH_START;
      neg_q   <= 1'b0;
      bad_q   <= 1'b0;
      sat_q   <= 1'b0;
      mag_q   <= '0;
      place_q <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      bad_q   <= bad_d;
      sat_q   <= sat_d;
      mag_q   <= mag_d;
      place_q <= place_d;
    end
  end

endmodule

// File: rtl/dttf_out_reg.sv
`timescale 1ns / 1ps

module dttf_out_reg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  dttf_pkg::dttf_result_t            res_i,
  output logic                              free_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dttf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata  // [63:0] value, [64] valid_res,
                                                          // [65] overflow
);

  logic                   valid_q, valid_d;
  dttf_pkg::dttf_result_t res_q, res_d;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {6'b0, res_q};

endmodule

// File: rtl/decimal_text_to_fixed_parser.sv
// Decimal text to signed fixed-point parser.
// Slave stream: one text byte per transfer in s_axis_tdata. A NUL byte ends
//   the string; every other byte updates the parse state and yields nothing.
// Master stream: one result per NUL, 72-bit tdata holding the Q(63-F).F value
//   (two's complement, F = FRAC_BITS), then valid_res and overflow flags.
// Throughput: one byte per cycle, sustained while the result register can take
//   each NUL. Each digit costs one times-ten add or one digit-times-ROM-weight
//   add into the magnitude register.
// Result path: an accepted NUL is held in the input register, then the parse
//   stage loads its result into the result register, which drives the master side.
// Stall: the result register holds its transfer until taken; bytes other than
//   NUL keep flowing meanwhile, a NUL waits in the input register until the
//   result register frees up, and s_axis_tready drops only then.
// Reset (rst_ni low, asynchronous): both stream sides go empty and the parser
//   returns to the start of a string with a zero magnitude.
`timescale 1ns / 1ps
`include "decimal_text_to_fixed_parser_macros.svh"

module decimal_text_to_fixed_parser #(
  parameter int FRAC_BITS       = 32,  // fraction bits of the result, 8..48
  parameter int MAX_FRAC_DIGITS = 12   // fraction digits that count, 1..15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dttf_pkg::CHAR_W-1:0]       s_axis_tdata,  // [7:0] character
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dttf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [63:0] value, [64] valid_res,
                                                           // [65] overflow
);

  dttf_pkg::dttf_step_t   step;     // byte leaving the input register
  dttf_pkg::dttf_result_t result;   // result seen at a terminating NUL
  logic                   out_free;
  logic                   load_res;

  // Input register: one byte held ahead of the parse stage.
  dttf_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .out_free_i    (out_free),
    .step_o        (step)
  );

  // Parse stage: string state and the magnitude accumulator.
  dttf_core #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_o  (result)
  );

  // Only a NUL moving through the parse stage produces a transfer.
  assign load_res = step.step && (step.character == dttf_pkg::CH_NUL);

  // Result register on the master side.
  dttf_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load_res),
    .res_i         (result),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Overflow is only ever reported on a well-formed string.
  `DTTF_ASSERT_IMP(a_ovf_needs_valid, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[65], m_axis_tdata[64], "overflow flagged on invalid string")
  // A rejected string always carries a zero value.
  `DTTF_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[64], m_axis_tdata[63:0] == 64'd0, "invalid string with nonzero value")
  // A NUL leaving the parse stage must show up as a pending result.
  `DTTF_ASSERT_NXT(a_nul_loads, clk_i, rst_ni, load_res, m_axis_tvalid, "terminating NUL produced no result")
  // A NUL may only leave the parse stage when the result register has room.
  `DTTF_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, load_res, out_free, "result register overwritten")

endmodule

// File: tb/decimal_text_to_fixed_parser_tb.sv
`timescale 1ns / 1ps

module decimal_text_to_fixed_parser_tb;

  localparam int FRAC_BITS       = 32;
  localparam int MAX_FRAC_DIGITS = 12;
  localparam int NUMBER_CHARS    = 1300;    // well-formed (or lightly damaged) numbers
  localparam int NOISE_CHARS     = 400;     // junk bytes and broken strings
  localparam int CYCLE_LIMIT     = 400000;
  localparam int TAIL_CYCLES     = 20;      // result lands in the cycle after its NUL leaves
  localparam int REPORT_LIMIT    = 10;

  // Magnitude ceiling as a 64-bit unsigned, top bit clear.
  localparam logic [63:0] MAG_LIMIT = {1'b0, dttf_pkg::MAG_MAX};

  logic                             clk_i;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [dttf_pkg::CHAR_W-1:0]      s_axis_tdata  = '0;   // [7:0] character
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [dttf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;  // [63:0] value, [64] valid_res, [65] overflow

  decimal_text_to_fixed_parser #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parse predictor: mirrors the string state held by the block, one byte at a
  // time, and queues the result that each NUL should produce.
  // ---------------------------------------------------------------------------
  dttf_pkg::dttf_phase_e  parse_phase;
  logic                   parse_negative;
  logic                   parse_bad;
  logic                   parse_saturated;
  logic [63:0]            parse_magnitude;
  int unsigned            parse_places;

  dttf_pkg::dttf_result_t expected_results[$];

  int unsigned  chars_sent;
  int unsigned  strings_valid;
  int unsigned  strings_saturated;
  int unsigned  strings_malformed;
  int unsigned  results_checked;
  int unsigned  failures;

  // Weight of the k-th fraction digit: 10^-k in Q64, brought down to FRAC_BITS
  // with round half up.
  function automatic logic [63:0] place_weight(input int unsigned k);
    logic [63:0] q64;
    q64 = dttf_pkg::TENTH_POW_Q64[k];
    return (q64 >> (64 - FRAC_BITS)) + ((q64 >> (63 - FRAC_BITS)) & 64'd1);
  endfunction

  task automatic clear_parse();
    parse_phase     = dttf_pkg::PH_START;
    parse_negative  = 1'b0;
    parse_bad       = 1'b0;
    parse_saturated = 1'b0;
    parse_magnitude = '0;
    parse_places    = 0;
  endtask

  task automatic predict_char(input logic [dttf_pkg::CHAR_W-1:0] c);
    dttf_pkg::dttf_result_t res;
    logic [63:0]            digit;
    logic [63:0]            addend;
    logic                   is_digit;
    is_digit = (c >= dttf_pkg::CH_ZERO) && (c <= dttf_pkg::CH_NINE);
    digit    = 64'(c - dttf_pkg::CH_ZERO);
    if (c == dttf_pkg::CH_NUL) begin
      res           = '0;
      res.valid_res = !parse_bad && (parse_phase != dttf_pkg::PH_POINT);
      if (res.valid_res) begin
        res.value    = parse_negative ? (64'd0 - parse_magnitude) : parse_magnitude;
        res.overflow = parse_saturated;
      end
      expected_results.push_back(res);
      if (!res.valid_res) strings_malformed++;
      else if (res.overflow) strings_saturated++;
      else strings_valid++;
      clear_parse();
    end else if (!parse_bad) begin
      case (parse_phase)
        dttf_pkg::PH_START, dttf_pkg::PH_INT: begin
          if (parse_phase == dttf_pkg::PH_START &&
              (c == dttf_pkg::CH_PLUS || c == dttf_pkg::CH_MINUS)) begin
            parse_negative = (c == dttf_pkg::CH_MINUS);
            parse_phase    = dttf_pkg::PH_INT;
          end else if (is_digit) begin
            // times ten plus digit; once saturated, further digits are ignored
            addend = digit << FRAC_BITS;
            if (!parse_saturated) begin
              if (addend > MAG_LIMIT ||
                  parse_magnitude > (MAG_LIMIT - addend) / 64'd10) begin
                parse_magnitude = MAG_LIMIT;
                parse_saturated = 1'b1;
              end else begin
                parse_magnitude = parse_magnitude * 64'd10 + addend;
              end
            end
            parse_phase = dttf_pkg::PH_INT;
          end else if (c == dttf_pkg::CH_POINT) begin
            parse_phase = dttf_pkg::PH_POINT;
          end else begin
            parse_bad = 1'b1;
          end
        end
        default: begin
          // after the point only digits; those past MAX_FRAC_DIGITS are checked only
          if (is_digit) begin
            if (parse_places < MAX_FRAC_DIGITS) begin
              parse_places++;
              if (!parse_saturated) begin
                addend = digit * place_weight(parse_places);
                if (addend > MAG_LIMIT - parse_magnitude) begin
                  parse_magnitude = MAG_LIMIT;
                  parse_saturated = 1'b1;
                end else begin
                  parse_magnitude = parse_magnitude + addend;
                end
              end
            end
            parse_phase = dttf_pkg::PH_FRAC;
          end else begin
            parse_bad = 1'b1;
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps. A max_gap of
  // zero gives a stretch with no idling at all.
  // ---------------------------------------------------------------------------
  int          burst_left;
  int unsigned max_gap;

  task automatic send_char(input logic [dttf_pkg::CHAR_W-1:0] c);
    int unsigned gap;
    if (max_gap != 0 && burst_left <= 0) begin
      gap = $urandom_range(max_gap, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    // tready read here is the value seen at the edge, before any update
    do @(posedge clk_i); while (!s_axis_tready);
    predict_char(c);
    chars_sent++;
  endtask

  task automatic send_string(input string text);
    foreach (text[i]) send_char(text[i]);
    send_char(dttf_pkg::CH_NUL);
  endtask

  function automatic logic [dttf_pkg::CHAR_W-1:0] random_digit(input bit nines);
    return nines ? dttf_pkg::CH_NINE
                 : dttf_pkg::CHAR_W'(dttf_pkg::CH_ZERO + $urandom_range(9, 0));
  endfunction

  // A number with random sign, digit counts and content. With damage set, one
  // flaw goes in: a stray byte, an extra point or sign, or a trailing point.
  task automatic send_random_number(input bit damage);
    logic [dttf_pkg::CHAR_W-1:0] text[$];
    int unsigned                 n_int;
    int unsigned                 n_frac;
    int unsigned                 pos;
    bit                          nines;
    case ($urandom_range(3, 0))
      2:       text.push_back(dttf_pkg::CH_PLUS);
      3:       text.push_back(dttf_pkg::CH_MINUS);
      default: ;
    endcase
    nines = ($urandom_range(7, 0) == 0);
    // mostly in range; now and then long enough to saturate
    n_int = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 10) : $urandom_range(9, 0);
    repeat (n_int) text.push_back(random_digit(nines));
    if ($urandom_range(9, 0) < 6) begin
      text.push_back(dttf_pkg::CH_POINT);
      n_frac = ($urandom_range(7, 0) == 0) ? $urandom_range(18, 10) : $urandom_range(8, 1);
      repeat (n_frac) text.push_back(random_digit(nines));
    end
    if (damage) begin
      pos = $urandom_range(text.size(), 0);
      case ($urandom_range(3, 0))
        0:       text.insert(pos, dttf_pkg::CHAR_W'($urandom_range(255, 1)));
        1:       text.insert(pos, dttf_pkg::CH_POINT);
        2:       text.insert(pos, $urandom_range(1, 0) ? dttf_pkg::CH_PLUS
                                                       : dttf_pkg::CH_MINUS);
        default: text.push_back(dttf_pkg::CH_POINT);
      endcase
    end
    foreach (text[i]) send_char(text[i]);
    send_char(dttf_pkg::CH_NUL);
  endtask

  task automatic send_random_noise();
    int unsigned len;
    len = $urandom_range(12, 0);
    repeat (len) send_char(dttf_pkg::CHAR_W'($urandom_range(255, 1)));
    send_char(dttf_pkg::CH_NUL);
  endtask

  task automatic pick_idling();
    case ($urandom_range(3, 0))
      0:       max_gap = 0;
      1:       max_gap = 2;
      2:       max_gap = 5;
      default: max_gap = 10;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result check. tready follows a rotating 16-bit pattern that
  // is redrawn periodically, sometimes to all ones for a stall-free stretch.
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pattern = 16'hFFFF;
  int unsigned cycle_count;

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("[%0t] %s mismatch: expected 0x%016h, got 0x%016h", $realtime, what, want, got);
  endtask

  task automatic check_result(input dttf_pkg::dttf_result_t got);
    dttf_pkg::dttf_result_t want;
    results_checked++;
    if (expected_results.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("[%0t] result transfer with nothing expected: 0x%017h", $realtime, got);
    end else begin
      want = expected_results.pop_front();
      if (got.value !== want.value) note_mismatch("value", want.value, got.value);
      if (got.valid_res !== want.valid_res)
        note_mismatch("valid_res", 64'(want.valid_res), 64'(got.valid_res));
      if (got.overflow !== want.overflow)
        note_mismatch("overflow", 64'(want.overflow), 64'(got.overflow));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("TEST FAILED");
        $finish;
      end else begin
        if (m_axis_tvalid && m_axis_tready)
          check_result(dttf_pkg::dttf_result_t'(
            m_axis_tdata[$bits(dttf_pkg::dttf_result_t)-1:0]));
        if (cycle_count % 97 == 0)
          stall_pattern = ($urandom_range(2, 0) == 0) ? 16'hFFFF : 16'($urandom()) | 16'h0001;
        else
          stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
        m_axis_tready <= stall_pattern[0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_and_sign();
    max_gap = 0;
    send_string("");
    send_string("+");
    send_string("-");
    send_string("0");
    send_string("-0");
    send_string("+7");
  endtask

  // Largest in-range integer, the first one past it, and digits after saturation.
  task automatic test_integer_range();
    max_gap = 3;
    send_string("9");
    send_string("2147483647");
    send_string("2147483648");
    send_string("-99999999999999999999");
    send_string("00000000000000000000001");
  endtask

  // Smallest weight in use, a digit past MAX_FRAC_DIGITS, and a fraction that may tip
  // the magnitude over its ceiling.
  task automatic test_fraction_digits();
    max_gap = 0;
    send_string(".5");
    send_string("-.25");
    send_string("0.000000000001");
    send_string("1.0000000000009");
    send_string("2147483647.99999999999999");
  endtask

  task automatic test_malformed();
    max_gap = 4;
    send_string("3.");        // point at the end
    send_string(".");         // point alone
    send_string("1.2.3");     // second point
    send_string("1-2");       // sign after a digit
    send_string("+-1");       // two signs
    send_string("1.-");       // sign in the fraction
    send_string("12a");
    send_string(" 1");
    send_char("1");           // top-bit bytes, then more digits still swallowed
    send_char(8'hFF);
    send_string("2");
    send_char(8'h80);
    send_char(dttf_pkg::CH_NUL);
  endtask

  task automatic test_random_numbers();
    int unsigned stop_at;
    stop_at = chars_sent + NUMBER_CHARS;
    pick_idling();
    while (chars_sent < stop_at) begin
      if ($urandom_range(15, 0) == 0) pick_idling();
      send_random_number($urandom_range(4, 0) == 0);
    end
  endtask

  task automatic test_random_noise();
    int unsigned stop_at;
    stop_at = chars_sent + NOISE_CHARS;
    while (chars_sent < stop_at) begin
      if ($urandom_range(7, 0) == 0) pick_idling();
      if ($urandom_range(1, 0) == 0) send_random_noise();
      else send_random_number(1'b1);
    end
  endtask

  initial begin
    clear_parse();
    max_gap    = 0;
    burst_left = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_sign();
    test_integer_range();
    test_fraction_digits();
    test_malformed();
    test_random_numbers();
    test_random_noise();
    s_axis_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d characters; checked %0d results in %0d cycles.",
             chars_sent, results_checked, cycle_count);
    $display("Strings: %0d in range, %0d saturated, %0d malformed; %0d failures.",
             strings_valid, strings_saturated, strings_malformed, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
